// ----- rtl/ifs_pkg.sv -----
// Shared types, constants and signature tables for the image format sniffer.
package ifs_pkg;

  // Width of the image length register, byte counter and reported offset.
  localparam int unsigned LenBits = 20;

  // Bytes of interest in the JPEG marker walk.
  localparam logic [7:0] ByteFill  = 8'hFF;
  localparam logic [7:0] ByteSoi   = 8'hD8;
  localparam logic [7:0] ByteSof0  = 8'hC0;
  localparam logic [7:0] ByteSof2  = 8'hC2;
  localparam logic [7:0] ByteEoi   = 8'hD9;

  // Number of signature bytes checked for PNG and for JPEG.
  localparam int unsigned PngSigLen  = 8;
  localparam int unsigned JpegSigLen = 3;

  // Result classes.
  typedef enum logic [1:0] {
    ClsUnknown     = 2'd0,
    ClsPng         = 2'd1,
    ClsBaseline    = 2'd2,
    ClsProgressive = 2'd3
  } class_e;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PhHeader = 5'b00001,
    PhAwait  = 5'b00010,
    PhFill   = 5'b00100,
    PhLenHi  = 5'b01000,
    PhLenLo  = 5'b10000
  } phase_e;

  // One image byte as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  // One classification result.
  typedef struct packed {
    class_e              image_class;
    logic [LenBits-1:0]  decided_offset;
  } result_t;

  // Expected PNG signature byte at a header position.
  function automatic logic [7:0] png_sig(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      3'd7:    val = 8'h0A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Expected JPEG signature byte at a header position (FF D8 FF).
  function automatic logic [7:0] jpeg_sig(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = ByteFill;
      2'd1:    val = ByteSoi;
      2'd2:    val = ByteFill;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/ifs_in_reg.sv -----
// Input register stage holding one accepted image byte.
module ifs_in_reg
  import ifs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // The register takes a new byte when empty or when its byte moves on.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/ifs_parser.sv -----
// Per-byte classification logic: signature check and JPEG marker walk.
module ifs_parser
  import ifs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  item_t              item_i,
  input  logic [LenBits-1:0] image_length_i,
  output logic               res_valid_o,
  output result_t            res_o
);

  phase_e             phase_q, phase_d;
  logic [LenBits-1:0] count_q, count_d;
  logic               png_match_q, png_match_d;
  logic               jpeg_match_q, jpeg_match_d;
  logic [7:0]         len_high_q, len_high_d;
  logic [LenBits-1:0] next_marker_q, next_marker_d;
  logic               sent_q, sent_d;

  logic               decided;
  class_e             cls;
  logic [7:0]         b;
  logic [LenBits:0]   len_ext;
  logic [LenBits:0]   i_plus1;
  logic [LenBits:0]   i_plus3;
  logic [15:0]        seg;
  logic [LenBits+1:0] pos;
  logic [LenBits+1:0] pos_plus4;

  assign b         = item_i.data_byte;
  assign len_ext   = {1'b0, image_length_i};
  assign i_plus1   = {1'b0, count_q} + (LenBits+1)'(1);
  assign i_plus3   = {1'b0, count_q} + (LenBits+1)'(3);
  assign seg       = {len_high_q, b};
  assign pos       = {2'b00, count_q} + (LenBits+2)'(seg) - (LenBits+2)'(1);
  assign pos_plus4 = pos + (LenBits+2)'(4);

  // Next state and decision for the byte in the input register.
  always_comb begin
    phase_d       = phase_q;
    count_d       = count_q;
    png_match_d   = png_match_q;
    jpeg_match_d  = jpeg_match_q;
    len_high_d    = len_high_q;
    next_marker_d = next_marker_q;
    sent_d        = sent_q;
    decided       = 1'b0;
    cls           = ClsUnknown;

    if (!sent_q) begin
      case (phase_q)
        PhHeader: begin
          if (image_length_i < LenBits'(PngSigLen)) begin
            decided = 1'b1;
            cls     = ClsUnknown;
          end else if (count_q < LenBits'(PngSigLen)) begin
            if (b != png_sig(count_q[2:0])) begin
              png_match_d = 1'b0;
            end
            if ((count_q < LenBits'(JpegSigLen)) && (b != jpeg_sig(count_q[1:0]))) begin
              jpeg_match_d = 1'b0;
            end
            // Byte 2 of a JPEG is already the first marker prefix.
            if ((count_q == LenBits'(2)) && jpeg_match_d) begin
              phase_d = PhFill;
            end else if (!png_match_d && !jpeg_match_d) begin
              decided = 1'b1;
              cls     = ClsUnknown;
            end else if ((count_q == LenBits'(PngSigLen - 1)) && png_match_d) begin
              decided = 1'b1;
              cls     = ClsPng;
            end
          end
        end
        PhAwait: begin
          // Skip segment payload until the next marker position.
          if (count_q >= next_marker_q) begin
            if (b != ByteFill) begin
              decided = 1'b1;
              cls     = ClsBaseline;
            end else if (i_plus1 >= len_ext) begin
              decided = 1'b1;
              cls     = ClsBaseline;
            end else begin
              phase_d = PhFill;
            end
          end
        end
        PhFill: begin
          // Fill bytes, then the marker code.
          if (b == ByteFill) begin
            if (i_plus1 >= len_ext) begin
              decided = 1'b1;
              cls     = ClsBaseline;
            end
          end else if ((b == ByteSof0) || (b == ByteEoi)) begin
            decided = 1'b1;
            cls     = ClsBaseline;
          end else if (b == ByteSof2) begin
            decided = 1'b1;
            cls     = ClsProgressive;
          end else if (i_plus3 > len_ext) begin
            decided = 1'b1;
            cls     = ClsBaseline;
          end else begin
            phase_d = PhLenHi;
          end
        end
        PhLenHi: begin
          len_high_d = b;
          phase_d    = PhLenLo;
        end
        PhLenLo: begin
          // Segment length known: check it and compute the next marker index.
          if (seg < 16'd2) begin
            decided = 1'b1;
            cls     = ClsBaseline;
          end else if (pos_plus4 > {1'b0, len_ext}) begin
            decided = 1'b1;
            cls     = ClsBaseline;
          end else begin
            next_marker_d = pos[LenBits-1:0];
            phase_d       = PhAwait;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      // The image ends while still undecided.
      if (!decided && (item_i.last || (i_plus1 >= len_ext))) begin
        decided = 1'b1;
        cls     = (phase_d == PhHeader) ? ClsUnknown : ClsBaseline;
      end

      if (decided) begin
        sent_d = 1'b1;
      end
    end

    // The last byte re-arms the parser for the next image.
    if (item_i.last) begin
      phase_d       = PhHeader;
      count_d       = '0;
      png_match_d   = 1'b1;
      jpeg_match_d  = 1'b1;
      len_high_d    = '0;
      next_marker_d = LenBits'(2);
      sent_d        = 1'b0;
    end else begin
      count_d = count_q + LenBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHeader;
      count_q       <= '0;
      png_match_q   <= 1'b1;
      jpeg_match_q  <= 1'b1;
      len_high_q    <= '0;
      next_marker_q <= LenBits'(2);
      sent_q        <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      count_q       <= count_d;
      png_match_q   <= png_match_d;
      jpeg_match_q  <= jpeg_match_d;
      len_high_q    <= len_high_d;
      next_marker_q <= next_marker_d;
      sent_q        <= sent_d;
    end
  end

  assign res_valid_o          = decided;
  assign res_o.image_class    = cls;
  assign res_o.decided_offset = count_q;

endmodule

// ----- rtl/ifs_out_reg.sv -----
// Result register that holds one classification until it is taken.
module ifs_out_reg
  import ifs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // A slot is free when empty or when its result leaves this cycle.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/image_format_sniffer.sv -----
// Top level of the image format sniffer.
// The block takes one image byte per clock cycle and reports one class per image
// (unknown, PNG, baseline JPEG or progressive JPEG) with the byte offset at which
// the class became final. Write the image length before the first byte of an image;
// the last flag re-arms the block for the next image. A byte passes an input register
// and is classified from it; the result that the byte decides is loaded into the result
// register when the byte leaves the input register, and is offered from there.
// Throughput is one byte per cycle; a byte is held in the input register only while
// the result register is full and not being taken.
module image_format_sniffer
  import ifs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LenBits-1:0] image_length_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         image_class_o,
  output logic [LenBits-1:0] decided_offset_o
);

  logic [LenBits-1:0] image_length_q;
  item_t              in_item;
  item_t              s1_item;
  logic               s1_valid;
  logic               advance;
  logic               out_free;
  logic               res_valid;
  result_t            res;
  result_t            out_res;

  // Image length register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      image_length_q <= image_length_i;
    end
  end

  assign in_item.data_byte = data_byte_i;
  assign in_item.last      = last_i;

  // The held byte is processed once the result register has room.
  assign advance = s1_valid && out_free;

  ifs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  ifs_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .item_i         (s1_item),
    .image_length_i (image_length_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  ifs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign image_class_o    = out_res.image_class;
  assign decided_offset_o = out_res.decided_offset;

`ifndef ASSERT_OFF
  // A PNG is only ever decided on the last signature byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (image_class_o == ClsPng) |-> decided_offset_o == LenBits'(PngSigLen - 1))
    else $error("PNG result at an offset other than the last signature byte");

  // A progressive JPEG needs at least one marker code after the signature.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (image_class_o == ClsProgressive) |-> decided_offset_o >= LenBits'(3))
    else $error("Progressive result before the first marker code");

  // A result is never loaded over one that has not been transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |-> !out_valid_o || out_ready_i)
    else $error("Result register overwritten while still holding a result");
`endif

endmodule

// ----- dv/tb_image_format_sniffer.sv -----
// Self-checking testbench for the image format sniffer.
module tb_image_format_sniffer;
  timeunit 1ns;
  timeprecision 1ps;
  import ifs_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_PHASE   = 2;
  localparam int unsigned LEN_MAX      = (1 << LenBits) - 1;

  // Signature bytes that the classifier compares against.
  localparam logic [7:0] PNG_MAGIC [PngSigLen] =
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [7:0] JPEG_MAGIC [JpegSigLen] = '{ByteFill, ByteSoi, ByteFill};

  // One directed byte, optionally preceded by a new image length.
  typedef struct packed {
    logic               new_len;
    logic [LenBits-1:0] len;
    logic [7:0]         data;
    logic               last;
    logic               typed;
    class_e             cls;
    logic [LenBits-1:0] off;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 23;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Short image: unknown on byte 0, then the rest is ignored.
    '{1'b1, 20'd0, 8'h00, 1'b0, 1'b1, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hFF, 1'b1, 1'b0, ClsUnknown, 20'd0},
    // Full PNG signature.
    '{1'b1, 20'd8, 8'h89, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h50, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h4E, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h47, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h0D, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h0A, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h1A, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h0A, 1'b1, 1'b1, ClsPng,     20'd7},
    // Segment length below two.
    '{1'b1, 20'd9, 8'hFF, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hD8, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hFF, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hE0, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h00, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'h01, 1'b1, 1'b1, ClsBaseline, 20'd5},
    // Progressive marker with the largest image length.
    '{1'b1, LEN_MAX[LenBits-1:0], 8'hFF, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hD8, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hFF, 1'b0, 1'b0, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hC2, 1'b0, 1'b1, ClsProgressive, 20'd3},
    '{1'b0, 20'd0, 8'h00, 1'b1, 1'b0, ClsUnknown, 20'd0},
    // No signature, and a stream that ends in the header.
    '{1'b0, 20'd0, 8'h00, 1'b1, 1'b1, ClsUnknown, 20'd0},
    '{1'b0, 20'd0, 8'hFF, 1'b1, 1'b1, ClsUnknown, 20'd0}
  };

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [LenBits-1:0] image_length_i = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i    = '0;
  logic               last_i         = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [1:0]         image_class_o;
  logic [LenBits-1:0] decided_offset_o;

  image_format_sniffer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .image_length_i   (image_length_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .image_class_o    (image_class_o),
    .decided_offset_o (decided_offset_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Classifier state mirrored by the testbench.
  phase_e             sn_phase;
  logic [LenBits-1:0] sn_count;
  logic               sn_png_ok;
  logic               sn_jpeg_ok;
  logic [7:0]         sn_len_hi;
  logic [LenBits-1:0] sn_next_marker;
  logic               sn_done;
  logic [LenBits-1:0] sn_length;

  result_t            awaited_verdicts [$];
  logic [7:0]         img_bytes [$];
  int unsigned        mismatches     = 0;
  int unsigned        bytes_streamed = 0;
  int unsigned        quiet_cycles   = 0;
  int unsigned        tx_level       = 1;
  int unsigned        rx_level       = 1;
  bit                 hold_req       = 1'b0;

  // Return the per-image state to its idle values.
  function automatic void sniff_rearm();
    sn_phase       = PhHeader;
    sn_count       = '0;
    sn_png_ok      = 1'b1;
    sn_jpeg_ok     = 1'b1;
    sn_len_hi      = '0;
    sn_next_marker = LenBits'(2);
    sn_done        = 1'b0;
  endfunction

  // Classify one byte; returns 1 when it settles the class of the image.
  function automatic bit sniff_byte(input logic [7:0] b, input logic lst,
                                    output result_t verdict);
    int unsigned i, len, seg, pos;
    bit          decided;
    class_e      cls;
    i       = sn_count;
    len     = sn_length;
    decided = 1'b0;
    cls     = ClsUnknown;
    verdict = '0;
    if (!sn_done) begin
      case (sn_phase)
        PhHeader: begin
          if (len < PngSigLen) begin
            decided = 1'b1;
          end else if (i < PngSigLen) begin
            if (b != PNG_MAGIC[i]) sn_png_ok = 1'b0;
            if (i < JpegSigLen && b != JPEG_MAGIC[i]) sn_jpeg_ok = 1'b0;
            if (i == 2 && sn_jpeg_ok) begin
              // The third signature byte is already the first marker prefix.
              sn_phase = PhFill;
            end else if (!sn_png_ok && !sn_jpeg_ok) begin
              decided = 1'b1;
            end else if (i == PngSigLen - 1 && sn_png_ok) begin
              decided = 1'b1;
              cls     = ClsPng;
            end
          end
        end
        PhAwait: begin
          if (i >= sn_next_marker) begin
            if (b != ByteFill || i + 1 >= len) begin
              decided = 1'b1;
              cls     = ClsBaseline;
            end else begin
              sn_phase = PhFill;
            end
          end
        end
        PhFill: begin
          if (b == ByteFill) begin
            if (i + 1 >= len) begin
              decided = 1'b1;
              cls     = ClsBaseline;
            end
          end else if (b == ByteSof0 || b == ByteEoi) begin
            decided = 1'b1;
            cls     = ClsBaseline;
          end else if (b == ByteSof2) begin
            decided = 1'b1;
            cls     = ClsProgressive;
          end else if (i + 3 > len) begin
            decided = 1'b1;
            cls     = ClsBaseline;
          end else begin
            sn_phase = PhLenHi;
          end
        end
        PhLenHi: begin
          sn_len_hi = b;
          sn_phase  = PhLenLo;
        end
        default: begin
          seg = {sn_len_hi, b};
          pos = i + seg - 1;
          if (seg < 2 || pos + 4 > len) begin
            decided = 1'b1;
            cls     = ClsBaseline;
          end else begin
            sn_next_marker = pos[LenBits-1:0];
            sn_phase       = PhAwait;
          end
        end
      endcase
      // End of the image while still undecided.
      if (!decided && (lst || i + 1 >= len)) begin
        decided = 1'b1;
        cls     = (sn_phase == PhHeader) ? ClsUnknown : ClsBaseline;
      end
      if (decided) begin
        verdict.image_class    = cls;
        verdict.decided_offset = sn_count;
        sn_done                = 1'b1;
      end
    end
    if (lst) sniff_rearm();
    else sn_count = sn_count + 1'b1;
    return decided;
  endfunction

  // Idle cycles before a transfer: mostly none or short, now and then long.
  function automatic int unsigned idle_gap(input int unsigned level);
    int unsigned r;
    if (level == 0) return 0;
    r = $urandom_range(99);
    if (r < ((level == 1) ? 70 : 35)) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return $urandom_range(0, 7);
    if (r < 70) return $urandom_range(8, 48);
    if (r < 88) return $urandom_range(49, 300);
    if (r < 95) return $urandom_range(301, LEN_MAX - 1);
    return LEN_MAX;
  endfunction

  // Marker walk of random segments, ending in a frame marker, an end marker,
  // a run of fill bytes, or simply at the target size.
  function automatic void build_jpeg(input int unsigned target);
    int unsigned fill, pick, seg, k;
    logic [7:0]  code;
    img_bytes.push_back(ByteFill);
    img_bytes.push_back(ByteSoi);
    while (img_bytes.size() < target) begin
      fill = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : 0;
      repeat (fill + 1) img_bytes.push_back(ByteFill);
      pick = $urandom_range(99);
      if (pick < 5) begin
        while (img_bytes.size() < target) img_bytes.push_back(ByteFill);
        break;
      end
      if (pick < 17) begin
        case ($urandom_range(2))
          0:       img_bytes.push_back(ByteSof0);
          1:       img_bytes.push_back(ByteSof2);
          default: img_bytes.push_back(ByteEoi);
        endcase
        break;
      end
      do begin
        code = 8'($urandom_range(255));
      end while (code == ByteFill || code == ByteSof0 || code == ByteSof2 || code == ByteEoi);
      img_bytes.push_back(code);
      // Segment sizes: too small, huge, landing next to the end, or ordinary.
      pick = $urandom_range(99);
      if (pick < 5) seg = $urandom_range(1);
      else if (pick < 10) seg = $urandom_range(65535);
      else if (pick < 22 && target >= img_bytes.size() + 6)
        seg = target + $urandom_range(1) - 4 - img_bytes.size();
      else seg = $urandom_range(2, 20);
      img_bytes.push_back(seg[15:8]);
      img_bytes.push_back(seg[7:0]);
      for (k = 2; k < seg && img_bytes.size() < target; k++)
        img_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  // One random image for the current length register.
  function automatic void build_image(input int unsigned len);
    int unsigned target, kind, n, k;
    img_bytes.delete();
    if (len < PngSigLen) target = $urandom_range(1, 10);
    else if (len <= 48 || (len <= 300 && $urandom_range(3) == 0)) target = len;
    else target = $urandom_range(8, 48);
    kind = $urandom_range(99);
    if (kind < 45) begin
      build_jpeg(target);
    end else if (kind < 60) begin
      // Broken marker walk.
      build_jpeg(target);
      img_bytes[$urandom_range(img_bytes.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 75) begin
      for (k = 0; k < PngSigLen; k++) img_bytes.push_back(PNG_MAGIC[k]);
      if ($urandom_range(3) == 0)
        img_bytes[$urandom_range(PngSigLen - 1)] = 8'($urandom_range(255));
    end else if (kind < 88) begin
      // Signature cut short by the last flag.
      if ($urandom_range(1)) begin
        n = $urandom_range(1, PngSigLen);
        for (k = 0; k < n; k++) img_bytes.push_back(PNG_MAGIC[k]);
      end else begin
        n = $urandom_range(1, JpegSigLen);
        for (k = 0; k < n; k++) img_bytes.push_back(JPEG_MAGIC[k]);
      end
      return;
    end
    // Stream length: mostly the target, sometimes cut early or overlong.
    kind = $urandom_range(99);
    if (kind < 70) n = target;
    else if (kind < 85) n = $urandom_range(1, target);
    else n = target + $urandom_range(1, 6);
    while (img_bytes.size() < n) img_bytes.push_back(8'($urandom_range(255)));
    while (img_bytes.size() > n) void'(img_bytes.pop_back());
  endfunction

  // Offer one byte, wait for its transfer and record what it should produce.
  task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
                           input result_t typed_verdict);
    int unsigned gap;
    result_t     verdict;
    bit          got;
    gap = idle_gap(tx_level);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= lst;
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);
    got = sniff_byte(b, lst, verdict);
    if (typed) awaited_verdicts.push_back(typed_verdict);
    else if (got) awaited_verdicts.push_back(verdict);
    bytes_streamed++;
  endtask

  // Stop sending, let every awaited class arrive and the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LenBits-1:0] value);
    wait_idle();
    cfg_valid_i    <= 1'b1;
    image_length_i <= value;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sn_length = value;
  endtask

  // Compare each class transfer with the oldest awaited one.
  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: unexpected result, class %0d offset %0d", $time, image_class_o,
                 decided_offset_o);
        mismatches++;
      end else begin
        want = awaited_verdicts.pop_front();
        if (image_class_o !== want.image_class) begin
          $display("%0t: image_class expected %0d actual %0d", $time, want.image_class,
                   image_class_o);
          mismatches++;
        end
        if (decided_offset_o !== want.decided_offset) begin
          $display("%0t: decided_offset expected %0d actual %0d", $time,
                   want.decided_offset, decided_offset_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(negedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i === 1'b1 && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i === 1'b1) ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_image_format_sniffer: FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall_left, run_left;
    stall_left = 0;
    run_left   = 1;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        run_left--;
        if (run_left == 0) begin
          stall_left = idle_gap(rx_level);
          run_left   = $urandom_range(1, 30);
        end
      end
    end
  end

  // Reset, directed bytes, then random images grouped by image length.
  initial begin
    int unsigned len, n_img, phase_no, k, j;
    result_t     typed_verdict;
    sn_length = '0;
    sniff_rearm();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DIR_ROWS; k++) begin
      if (DIRECTED[k].new_len) write_length(DIRECTED[k].len);
      typed_verdict.image_class    = DIRECTED[k].cls;
      typed_verdict.decided_offset = DIRECTED[k].off;
      send_byte(DIRECTED[k].data, DIRECTED[k].last, DIRECTED[k].typed, typed_verdict);
    end

    phase_no = 0;
    while (bytes_streamed < DIR_ROWS + RANDOM_BYTES) begin
      len = pick_length();
      write_length(len[LenBits-1:0]);
      tx_level = $urandom_range(2);
      rx_level = $urandom_range(2);
      n_img    = $urandom_range(1, 6);
      if (phase_no == HOLD_PHASE) begin
        // Keep offering bytes while the result side holds off.
        hold_req = 1'b1;
        tx_level = 0;
        n_img    = 12;
      end
      for (k = 0; k < n_img; k++) begin
        build_image(len);
        for (j = 0; j < img_bytes.size(); j++)
          send_byte(img_bytes[j], j == img_bytes.size() - 1, 1'b0, '0);
      end
      phase_no++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_image_format_sniffer: PASS");
    end else begin
      $display("tb_image_format_sniffer: FAIL");
    end
    $finish;
  end

endmodule
